/* sv/tmkd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmkd_pkg: shared types and constants
// Holds the sequencer states, the register map and the fixed-point widths for
// the trimmed-mean Kalman distance conditioner.
// ----------------------------------------------------------------------------
package tmkd_pkg;

  // Fixed-point widths of the datapath.
  localparam int SUM_W  = 22;  // window sum
  localparam int SMP_W  = 16;  // raw sample
  localparam int EST_W  = 24;  // estimate, Q16.8
  localparam int COV_W  = 17;  // covariance, Q16
  localparam int PM_W   = 18;  // predicted covariance
  localparam int DEN_W  = 19;  // gain denominator
  localparam int GAIN_W = 17;  // gain, Q16, at most 1.0
  localparam int DVD_W  = 34;  // divider dividend and quotient
  localparam int MA_W   = 24;  // multiplier operand a
  localparam int MB_W   = 18;  // multiplier operand b
  localparam int MP_W   = MA_W + MB_W;
  localparam int CFG_W  = 17;  // widest register

  localparam logic [GAIN_W-1:0] ONE_Q16 = 17'd65536;

  // Register map.
  localparam logic [2:0] CFG_PROCESS_NOISE     = 3'd0;
  localparam logic [2:0] CFG_MEASUREMENT_NOISE = 3'd1;
  localparam logic [2:0] CFG_SCALE_CH0         = 3'd2;
  localparam logic [2:0] CFG_OFFSET_CH0        = 3'd3;
  localparam logic [2:0] CFG_SCALE_CH1         = 3'd4;
  localparam logic [2:0] CFG_OFFSET_CH1        = 3'd5;

  // Register reset values.
  localparam logic [15:0]        RST_PROCESS_NOISE     = 16'd590;
  localparam logic [15:0]        RST_MEASUREMENT_NOISE = 16'd11796;
  localparam logic [16:0]        RST_SCALE             = 17'd15303;
  localparam logic signed [15:0] RST_OFFSET            = -16'sd2487;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MEAN_GO,
    ST_MEAN_WAIT,
    ST_GAIN_GO,
    ST_GAIN_WAIT,
    ST_CORR,
    ST_EST,
    ST_COV,
    ST_CAL,
    ST_FINISH
  } tmkd_state_t;

  // Divider control and status.
  typedef struct packed {
    logic start;
  } tmkd_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } tmkd_div_sts_t;

endpackage
`default_nettype wire

/* sv/trimmed_mean_kalman_distance.sv */
`timescale 1ns / 1ps
`default_nettype none
// A plain sample is taken one per cycle while in_stall is low. A closing sample
// of a window of at least three samples stalls the input through the mean and
// gain divider runs of 34 quotient bits (no gain run with a zero denominator),
// the sequencer steps and any output stall.
// Reset: synchronous active-low rst_n restores registers, clears the windows,
// zeroes the estimates and sets each covariance to 1.0.
// ----------------------------------------------------------------------------
// trimmed_mean_kalman_distance: two-channel distance conditioner
// Accumulates windows, forms the trimmed mean, runs a scalar Kalman filter per
// channel and applies a gain and offset with 16-bit saturation.
// ----------------------------------------------------------------------------
module trimmed_mean_kalman_distance #(
  parameter int WINDOW_MAX = 64,
  parameter int CHANNELS   = 2
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [2:0]                    cfg_index,
  input  wire logic [tmkd_pkg::CFG_W-1:0]    cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic                          in_channel,
  input  wire logic [15:0]                   in_sample,
  input  wire logic                          in_last_of_window,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic signed [15:0]                 out_distance,
  output logic                               out_result_channel,
  output logic                               out_saturated
);
  import tmkd_pkg::*;

  localparam int CNT_W = $clog2(WINDOW_MAX + 1);

  // Configuration registers.
  logic [15:0]        pn_r, mn_r;
  logic [16:0]        scale_r [2];
  logic signed [15:0] offset_r [2];

  // Window and filter state per channel.
  logic [SUM_W-1:0] wsum_r [2];
  logic [SMP_W-1:0] wmin_r [2];
  logic [SMP_W-1:0] wmax_r [2];
  logic [CNT_W-1:0] wcnt_r [2];
  logic [EST_W-1:0] est_r [2];
  logic [COV_W-1:0] cov_r [2];

  // Sequencer and working registers.
  tmkd_state_t      state_r, state_nxt;
  logic             ch_r;
  logic [SUM_W-1:0] num_r;
  logic [CNT_W-1:0] dvs_r;
  logic [EST_W-1:0] mean_r;
  logic [PM_W-1:0]  pm_r;
  logic [GAIN_W-1:0] gain_r;
  logic signed [15:0] res_dist_r;
  logic             res_sat_r;
  logic             out_valid_r;
  logic signed [15:0] out_dist_r;
  logic             out_ch_r;
  logic             out_sat_r;

  // Accept and new window values.
  logic             in_acc, ch_ok, do_acc;
  logic [SUM_W-1:0] nsum;
  logic [SMP_W-1:0] nmin, nmax;
  logic [CNT_W-1:0] ncnt;
  logic             close_ok;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign ch_ok    = (CHANNELS > 1) || (in_channel == 1'b0);

  always_comb begin
    nsum   = wsum_r[in_channel];
    nmin   = wmin_r[in_channel];
    nmax   = wmax_r[in_channel];
    ncnt   = wcnt_r[in_channel];
    do_acc = (32'(wcnt_r[in_channel]) < WINDOW_MAX);
    if (do_acc) begin
      if (wcnt_r[in_channel] == '0) begin
        nmin = in_sample;
        nmax = in_sample;
      end else begin
        if (in_sample < nmin) nmin = in_sample;
        if (in_sample > nmax) nmax = in_sample;
      end
      nsum = SUM_W'(wsum_r[in_channel] + SUM_W'(in_sample));
      ncnt = wcnt_r[in_channel] + 1'b1;
    end
    close_ok = (32'(ncnt) >= 3);
  end

  // Divider and multiplier hookup.
  tmkd_div_ctl_t     div_ctl;
  tmkd_div_sts_t     div_sts;
  logic [DVD_W-1:0]  div_dvd, div_q;
  logic [DEN_W-1:0]  div_dvs;
  logic [DEN_W-1:0]  den;
  logic [MA_W-1:0]   mul_a;
  logic [MB_W-1:0]   mul_b;
  logic [MP_W-1:0]   mul_p;

  tmkd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .sts      (div_sts),
    .quotient (div_q)
  );

  tmkd_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p_r (mul_p)
  );

  assign den = DEN_W'(pm_r) + DEN_W'(mn_r);

  // Correction terms.
  logic [EST_W:0]    delta, ndelta;
  logic              neg;
  logic [EST_W-1:0]  mag, corr, est_new;
  logic [GAIN_W:0]   omg_w;
  logic [GAIN_W-1:0] omg;

  always_comb begin
    delta   = {1'b0, mean_r} - {1'b0, est_r[ch_r]};
    ndelta  = -delta;
    neg     = delta[EST_W];
    mag     = neg ? ndelta[EST_W-1:0] : delta[EST_W-1:0];
    corr    = mul_p[EST_W+15:16];
    est_new = neg ? (est_r[ch_r] - corr) : (est_r[ch_r] + corr);
    omg_w   = {1'b0, ONE_Q16} - {1'b0, gain_r};
    omg     = omg_w[GAIN_W-1:0];
  end

  // Calibration: value = scale * estimate + offset * 2^24, truncated to zero.
  logic signed [42:0] val;
  logic signed [18:0] whole;
  logic               adj;

  always_comb begin
    val   = $signed({2'b00, mul_p[40:0]})
          + $signed({{3{offset_r[ch_r][15]}}, offset_r[ch_r], 24'b0});
    adj   = val[42] && (val[23:0] != '0);
    whole = $signed(val[42:24]) + $signed({18'b0, adj});
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && ch_ok && in_last_of_window && close_ok) state_nxt = ST_MEAN_GO;
      end
      ST_MEAN_GO:   state_nxt = ST_MEAN_WAIT;
      ST_MEAN_WAIT: if (div_sts.done) state_nxt = ST_GAIN_GO;
      ST_GAIN_GO:   state_nxt = (den == '0) ? ST_CORR : ST_GAIN_WAIT;
      ST_GAIN_WAIT: if (div_sts.done) state_nxt = ST_CORR;
      ST_CORR:      state_nxt = ST_EST;
      ST_EST:       state_nxt = ST_COV;
      ST_COV:       state_nxt = ST_CAL;
      ST_CAL:       state_nxt = ST_FINISH;
      ST_FINISH:    if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:      state_nxt = ST_IDLE;
    endcase
  end

  // Unit controls per state.
  always_comb begin
    div_ctl.start = 1'b0;
    div_dvd       = '0;
    div_dvs       = '0;
    mul_a         = '0;
    mul_b         = '0;
    unique case (state_r)
      ST_MEAN_GO: begin
        div_ctl.start = 1'b1;
        div_dvd       = DVD_W'({num_r, 8'b0});
        div_dvs       = DEN_W'(dvs_r);
      end
      ST_GAIN_GO: begin
        div_ctl.start = (den != '0);
        div_dvd       = {pm_r, 16'b0};
        div_dvs       = den;
      end
      ST_CORR: begin
        mul_a = mag;
        mul_b = MB_W'(gain_r);
      end
      ST_EST: begin
        mul_a = MA_W'(omg);
        mul_b = pm_r;
      end
      ST_COV: begin
        mul_a = est_r[ch_r];
        mul_b = MB_W'(scale_r[ch_r]);
      end
      default: begin
        mul_a = '0;
      end
    endcase
  end

  // Sequencer state and the per-channel window and filter state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      for (int i = 0; i < 2; i++) begin
        wsum_r[i] <= '0;
        wmin_r[i] <= '0;
        wmax_r[i] <= '0;
        wcnt_r[i] <= '0;
        est_r[i]  <= '0;
        cov_r[i]  <= ONE_Q16;
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc && ch_ok) begin
        if (in_last_of_window) begin
          wsum_r[in_channel] <= '0;
          wmin_r[in_channel] <= '0;
          wmax_r[in_channel] <= '0;
          wcnt_r[in_channel] <= '0;
        end else begin
          wsum_r[in_channel] <= nsum;
          wmin_r[in_channel] <= nmin;
          wmax_r[in_channel] <= nmax;
          wcnt_r[in_channel] <= ncnt;
        end
      end
      if (state_r == ST_EST) est_r[ch_r] <= est_new;
      if (state_r == ST_COV) cov_r[ch_r] <= mul_p[COV_W+15:16];
    end
  end

  // Working registers of one window close.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      ch_r  <= in_channel;
      num_r <= SUM_W'(nsum - SUM_W'(nmax) - SUM_W'(nmin));
      dvs_r <= ncnt - CNT_W'(2);
    end
    if (state_r == ST_MEAN_GO) pm_r <= PM_W'(cov_r[ch_r]) + PM_W'(pn_r);
    if (state_r == ST_MEAN_WAIT && div_sts.done) mean_r <= div_q[EST_W-1:0];
    if (state_r == ST_GAIN_GO && den == '0) gain_r <= ONE_Q16;
    if (state_r == ST_GAIN_WAIT && div_sts.done) gain_r <= div_q[GAIN_W-1:0];
    if (state_r == ST_CAL) begin
      if (whole > 19'sd32767) begin
        res_dist_r <= 16'sh7fff;
        res_sat_r  <= 1'b1;
      end else if (whole < -19'sd32768) begin
        res_dist_r <= -16'sh8000;
        res_sat_r  <= 1'b1;
      end else begin
        res_dist_r <= whole[15:0];
        res_sat_r  <= 1'b0;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FINISH && (!out_valid_r || !out_stall)) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FINISH && (!out_valid_r || !out_stall)) begin
      out_dist_r <= res_dist_r;
      out_ch_r   <= ch_r;
      out_sat_r  <= res_sat_r;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_distance       = out_dist_r;
  assign out_result_channel = out_ch_r;
  assign out_saturated      = out_sat_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pn_r <= RST_PROCESS_NOISE;
      mn_r <= RST_MEASUREMENT_NOISE;
      for (int i = 0; i < 2; i++) begin
        scale_r[i]  <= RST_SCALE;
        offset_r[i] <= RST_OFFSET;
      end
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROCESS_NOISE:     pn_r        <= cfg_data[15:0];
        CFG_MEASUREMENT_NOISE: mn_r        <= cfg_data[15:0];
        CFG_SCALE_CH0:         scale_r[0]  <= cfg_data[16:0];
        CFG_OFFSET_CH0:        offset_r[0] <= cfg_data[15:0];
        CFG_SCALE_CH1:         scale_r[1]  <= cfg_data[16:0];
        CFG_OFFSET_CH1:        offset_r[1] <= cfg_data[15:0];
        default:               pn_r        <= pn_r;
      endcase
    end
  end

  // A new result is loaded only at the end of a window close.
  a_out_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == ST_FINISH)
    else $error("result appeared outside the finish step");
  a_gain_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_CORR |-> gain_r <= ONE_Q16)
    else $error("gain above 1.0");
  a_div_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_sts.done |-> (state_r == ST_MEAN_WAIT || state_r == ST_GAIN_WAIT))
    else $error("divider finished outside a wait step");
  a_est_hold: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != ST_EST |=> $stable(est_r[0]) && $stable(est_r[1]))
    else $error("estimate changed outside its update step");

endmodule
`default_nettype wire

/* sv/tmkd_div.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmkd_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle, shared by the window mean
// and the Kalman gain.
// ----------------------------------------------------------------------------
module tmkd_div (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire tmkd_pkg::tmkd_div_ctl_t       ctl,
  input  wire logic [tmkd_pkg::DVD_W-1:0]    dividend,
  input  wire logic [tmkd_pkg::DEN_W-1:0]    divisor,
  output tmkd_pkg::tmkd_div_sts_t            sts,
  output logic [tmkd_pkg::DVD_W-1:0]         quotient
);
  import tmkd_pkg::*;

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic [DVD_W-1:0] q_r, q_nxt;
  logic [DEN_W-1:0] rem_r, rem_nxt;
  logic [DEN_W-1:0] dvs_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [DEN_W:0]   trial;

  // Load on start; otherwise one restoring step: shift in the next dividend bit and try a subtract.
  always_comb begin
    trial    = {rem_r, q_r[DVD_W-1]};
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctl.start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      cnt_nxt  = CNT_W'(DVD_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = DEN_W'(trial - {1'b0, dvs_r});
        q_nxt   = {q_r[DVD_W-2:0], 1'b1};
      end else begin
        rem_nxt = trial[DEN_W-1:0];
        q_nxt   = {q_r[DVD_W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Working registers.
  always_ff @(posedge clk) begin
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    if (ctl.start) begin
      dvs_r <= divisor;
    end
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = q_r;

  // A result only follows a run of the divider.
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r)) else $error("divider done without a run");
  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.start |-> !busy_r) else $error("divider started while busy");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (cnt_r != '0)) else $error("divider count ran out while busy");

endmodule
`default_nettype wire

/* sv/tmkd_mul.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmkd_mul: shared multiplier
// Unsigned 24 x 18 multiply with a registered product; the sequencer uses it
// for the correction, the covariance update and the calibration gain.
// ----------------------------------------------------------------------------
module tmkd_mul (
  input  wire logic                       clk,
  input  wire logic [tmkd_pkg::MA_W-1:0]  a,
  input  wire logic [tmkd_pkg::MB_W-1:0]  b,
  output logic [tmkd_pkg::MP_W-1:0]       p_r
);
  import tmkd_pkg::*;

  // Product register.
  always_ff @(posedge clk) begin
    p_r <= MP_W'(a) * MP_W'(b);
  end

endmodule
`default_nettype wire

/* tb/tmkd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tmkd_checker: result predictor and comparator
// Watches the input, result and register channels of the distance conditioner,
// keeps its own model of the windows, filters and calibration registers, and
// compares each result item with the oldest predicted distance.
// ----------------------------------------------------------------------------
module tmkd_checker (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [tmkd_pkg::CFG_W-1:0] cfg_data,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_channel,
  input  logic [15:0]                in_sample,
  input  logic                       in_last_of_window,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic signed [15:0]         out_distance,
  input  logic                       out_result_channel,
  input  logic                       out_saturated,
  output int                         fail_count,
  output int                         pending
);
  import tmkd_pkg::*;

  typedef struct packed {
    logic signed [15:0] distance;
    logic               chan;
    logic               sat;
  } distance_t;

  distance_t  distance_q[$];

  logic [15:0] q_noise, r_noise;
  logic [16:0] scale [2];
  logic [15:0] offset [2];
  logic [21:0] win_sum [2];
  logic [15:0] win_min [2], win_max [2];
  logic [6:0]  win_cnt [2];
  logic [23:0] est [2];
  logic [16:0] cov [2];

  // Advance the model by one accepted sample; push a prediction on a close of at least three samples.
  task automatic predict_sample(input logic ch, input logic [15:0] s, input logic last);
    longint unsigned mean, pm, den, gain, mag;
    longint          delta, corr, value, whole;
    distance_t       d;
    int              n;
    if (win_cnt[ch] < 64) begin
      if (win_cnt[ch] == 0) begin
        win_min[ch] = s;
        win_max[ch] = s;
      end else begin
        if (s < win_min[ch]) win_min[ch] = s;
        if (s > win_max[ch]) win_max[ch] = s;
      end
      win_sum[ch] = win_sum[ch] + s;
      win_cnt[ch] = win_cnt[ch] + 1;
    end
    if (!last) return;
    n = win_cnt[ch];
    if (n >= 3) begin
      mean = ((64'(win_sum[ch]) - win_max[ch] - win_min[ch]) & 64'hFFFF_FFFF) << 8;
      mean = (mean / (n - 2)) & 64'hFFFF_FFFF;
      pm = (cov[ch] + q_noise) & 64'hFFFF_FFFF;
      den = (pm + r_noise) & 64'hFFFF_FFFF;
      gain = (den == 0) ? 65536 : ((pm << 16) / den) & 64'hFFFF_FFFF;
      delta = longint'(mean) - longint'(est[ch]);
      if (delta < 0) begin
        mag = (longint'(-delta) * gain) >> 16;
        corr = -longint'(mag);
      end else begin
        corr = (delta * longint'(gain)) >>> 16;
      end
      est[ch] = 24'(longint'(est[ch]) + corr);
      cov[ch] = 17'((((65536 - gain) & 64'hFFFF_FFFF) * pm) >> 16);
      value = longint'(scale[ch]) * longint'(est[ch])
              + longint'($signed(offset[ch])) * 64'sd16777216;
      whole = (value < 0) ? -((-value) >>> 24) : (value >>> 24);
      d.sat = 1'b0;
      if (whole > 32767) begin
        whole = 32767;
        d.sat = 1'b1;
      end
      if (whole < -32768) begin
        whole = -32768;
        d.sat = 1'b1;
      end
      d.distance = 16'(whole);
      d.chan = ch;
      distance_q.push_back(d);
    end
    win_sum[ch] = '0;
    win_min[ch] = '0;
    win_max[ch] = '0;
    win_cnt[ch] = '0;
  endtask

  // Track registers and inputs, and compare each result item.
  always @(posedge clk) begin
    distance_t d;
    if (!rst_n) begin
      q_noise = RST_PROCESS_NOISE;
      r_noise = RST_MEASUREMENT_NOISE;
      for (int c = 0; c < 2; c++) begin
        scale[c] = RST_SCALE;
        offset[c] = RST_OFFSET;
        win_sum[c] = '0;
        win_min[c] = '0;
        win_max[c] = '0;
        win_cnt[c] = '0;
        est[c] = '0;
        cov[c] = 17'd65536;
      end
      distance_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_PROCESS_NOISE:     q_noise = cfg_data[15:0];
          CFG_MEASUREMENT_NOISE: r_noise = cfg_data[15:0];
          CFG_SCALE_CH0:         scale[0] = cfg_data;
          CFG_OFFSET_CH0:        offset[0] = cfg_data[15:0];
          CFG_SCALE_CH1:         scale[1] = cfg_data;
          CFG_OFFSET_CH1:        offset[1] = cfg_data[15:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        predict_sample(in_channel, in_sample, in_last_of_window);
      if (out_valid && !out_stall) begin
        if (distance_q.size() == 0) begin
          $error("unexpected result item: distance %0d", out_distance);
          fail_count++;
        end else begin
          d = distance_q.pop_front();
          if (out_distance !== d.distance) begin
            $error("distance: expected %0d, got %0d", d.distance, out_distance);
            fail_count++;
          end
          if (out_result_channel !== d.chan) begin
            $error("result_channel: expected %0d, got %0d", d.chan, out_result_channel);
            fail_count++;
          end
          if (out_saturated !== d.sat) begin
            $error("saturated: expected %0d, got %0d", d.sat, out_saturated);
            fail_count++;
          end
        end
      end
    end
    // Number of predicted result items still to come.
    pending = distance_q.size();
  end
endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the trimmed-mean Kalman distance conditioner
// Drives directed and random sample windows on both channels across several
// register settings and idle patterns; a separate checker predicts and
// compares every result item.
// ----------------------------------------------------------------------------
module tb;
  import tmkd_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [2:0]         cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_channel = 1'b0;
  logic [15:0]        in_sample = '0;
  logic               in_last_of_window = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [15:0] out_distance;
  logic               out_result_channel;
  logic               out_saturated;
  int                 fail_count;
  int                 pending;
  int                 idle_pct = 0;
  int                 stall_pct = 0;
  longint             cycle = 0;

  trimmed_mean_kalman_distance uut (.*);
  tmkd_checker chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Receiver stalls at random; a cycle counter ends a hung run.
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    cycle <= cycle + 1;
    if (cycle > 3_000_000) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Offer one item, with random idle cycles before it, and wait until it is taken.
  // Valid stays high afterwards so that items can follow back to back.
  task automatic send_sample(input logic ch, input logic [15:0] s, input logic last);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_channel <= ch;
    in_sample <= s;
    in_last_of_window <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [CFG_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // Wait for every predicted result, then let a closing window with no result finish.
  task automatic drain();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (120) @(negedge clk);
  endtask

  task automatic send_window(input logic ch, input int n, input int mode);
    logic [15:0] s;
    for (int i = 0; i < n; i++) begin
      case (mode)
        0: s = 16'($urandom);
        1: s = 16'hFFFF;
        2: s = 16'h0000;
        default: s = 16'($urandom_range(4000)) + 16'd30000;
      endcase
      send_sample(ch, s, i == n - 1);
    end
  endtask

  function automatic int pick_len();
    int r;
    r = $urandom_range(99);
    if (r < 5) return $urandom_range(2, 1);
    if (r < 10) return $urandom_range(80, 60);
    return $urandom_range(12, 3);
  endfunction

  task automatic random_phase(input int items);
    int sent;
    int n;
    sent = 0;
    while (sent < items) begin
      if ($urandom_range(9) == 0) begin
        send_sample(1'($urandom), 16'($urandom), 1'b0);
        sent++;
      end else begin
        n = pick_len();
        send_window(1'($urandom), n, $urandom_range(3) == 0 ? 3 : 0);
        sent += n;
      end
    end
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: extremes of samples, short windows, overflowing windows, both channels.
    send_window(1'b0, 3, 1);
    send_window(1'b1, 3, 2);
    send_sample(1'b0, 16'd5, 1'b1);
    send_window(1'b1, 2, 0);
    send_window(1'b0, 4, 0);
    send_window(1'b1, 5, 3);
    drain();
    send_window(1'b0, 66, 1);
    drain();

    // Register extremes: largest scale, largest offsets, zero noise, a write to an unused index.
    write_reg(CFG_PROCESS_NOISE, 17'd0);
    write_reg(CFG_MEASUREMENT_NOISE, 17'd0);
    write_reg(CFG_SCALE_CH0, 17'h1FFFF);
    write_reg(CFG_OFFSET_CH0, 17'h07FFF);
    write_reg(CFG_SCALE_CH1, 17'h1FFFF);
    write_reg(CFG_OFFSET_CH1, 17'h08000);
    write_reg(3'd7, 17'h1FFFF);
    send_window(1'b0, 4, 1);
    send_window(1'b1, 4, 2);
    send_window(1'b1, 4, 1);
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 1) ? 50 : (ph == 3) ? 23 : 0;
      stall_pct = (ph == 2) ? 50 : (ph == 3) ? 23 : 0;
      write_reg(CFG_PROCESS_NOISE, (ph == 0) ? 17'hFFFF : 17'($urandom));
      write_reg(CFG_MEASUREMENT_NOISE, (ph == 1) ? 17'hFFFF : 17'($urandom));
      write_reg(CFG_SCALE_CH0, (ph == 2) ? 17'd0 : 17'($urandom));
      write_reg(CFG_OFFSET_CH0, 17'($urandom_range(65535)));
      write_reg(CFG_SCALE_CH1, (ph == 3) ? 17'd65536 : 17'($urandom));
      write_reg(CFG_OFFSET_CH1, (ph == 0) ? 17'd0 : 17'($urandom_range(65535)));
      random_phase(340);
      drain();
    end

    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end
endmodule

/* sim.f */
sv/tmkd_pkg.sv
sv/tmkd_div.sv
sv/tmkd_mul.sv
sv/trimmed_mean_kalman_distance.sv
tb/tmkd_checker.sv
tb/tb.sv
